@@ hdl/pps_pkg.sv @@
// ----------------------------------------------------------------------------
// pps_pkg
// Shared types, constants and helpers of the projection profile segmenter.
// ----------------------------------------------------------------------------
`default_nettype none

package pps_pkg;

    // Field widths fixed by the stream format.
    localparam int PIX_W = 8;
    localparam int POS_W = 10;
    localparam int CNT_W = 11;
    localparam int CFG_W = 11;
    localparam int CFG_IDX_W = 1;

    // Packed stream word widths.
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 48;

    // Default sizes and register reset values.
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;
    localparam logic [CFG_W-1:0] WIDTH_RST  = CFG_W'(640);
    localparam logic [CFG_W-1:0] HEIGHT_RST = CFG_W'(480);

    // Saturation limit of every count.
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // Input selector codes.
    localparam logic FUNC_PIXEL = 1'b0;
    localparam logic FUNC_READ  = 1'b1;

    // Output kind codes.
    localparam logic KIND_ROW = 1'b0;
    localparam logic KIND_COL = 1'b1;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

    // Word handed from the frame tracker to the column update stage.
    typedef struct packed {
        logic             is_read;
        logic             nz;
        logic             first_row;
        logic             in_range;
        logic             has_res;
        logic [POS_W-1:0] position;
        logic [CNT_W-1:0] row_count;
        logic             seg_valid;
        logic [POS_W-1:0] seg_start;
        logic [POS_W-1:0] seg_end;
    } pps_item_t;

    // Saturating add of one nonzero flag to a count.
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] cnt,
                                                 input logic nz);
        logic [CNT_W-1:0] res;
        begin
            if (nz && (cnt != CNT_MAX))
            begin
                res = cnt + CNT_W'(1);
            end
            else
            begin
                res = cnt;
            end
            return res;
        end
    endfunction

endpackage

`default_nettype wire

@@ hdl/pps_ram.sv @@
// ----------------------------------------------------------------------------
// pps_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module pps_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024
) (
    input  wire                      clk,
    input  wire                      wr_en,
    input  wire  [$clog2(DEPTH)-1:0] wr_addr,
    input  wire  [WIDTH-1:0]         wr_data,
    input  wire                      rd_en,
    input  wire  [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ hdl/pps_frame.sv @@
// ----------------------------------------------------------------------------
// pps_frame
// Raster position tracking, row counting and run detection; issues the
// column memory read for every accepted word.
// ----------------------------------------------------------------------------
`default_nettype none

module pps_frame #(
    parameter int MAX_WIDTH  = pps_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = pps_pkg::MAX_HEIGHT_DEF
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire  [pps_pkg::CFG_W-1:0]          width_cfg,
    input  wire  [pps_pkg::CFG_W-1:0]          height_cfg,
    input  wire                                accept,
    input  wire                                func,
    input  wire  [pps_pkg::PIX_W-1:0]          pixel_value,
    input  wire  [pps_pkg::POS_W-1:0]          read_column,
    output logic [$clog2(MAX_WIDTH)-1:0]       rd_addr,
    output logic                               s1_valid_reg,
    output pps_pkg::pps_item_t                 s1_item_reg,
    output logic [$clog2(MAX_WIDTH)-1:0]       s1_addr_reg,
    input  wire                                s1_adv
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int WC_W  = COL_W + 1;
    localparam int HC_W  = ROW_W + 1;
    localparam int CW_A  = (WC_W > pps_pkg::CFG_W) ? WC_W : pps_pkg::CFG_W;
    localparam int CMP_W = (HC_W > CW_A) ? HC_W : CW_A;

    logic [COL_W-1:0]          col_reg, col_next;
    logic [ROW_W-1:0]          row_reg, row_next;
    logic [pps_pkg::CNT_W-1:0] acc_reg, acc_next;
    logic                      run_open_reg, run_open_next;
    logic [ROW_W-1:0]          run_start_reg, run_start_next;

    logic [CMP_W-1:0]          w_eff, h_eff, col_inc, row_inc, rcol_ext;
    logic [CMP_W-1:0]          row_ext, start_ext, end_ext;
    logic                      nz, last_col, last_row;
    logic [pps_pkg::CNT_W-1:0] acc_sum;
    logic                      seg_valid;
    logic [ROW_W-1:0]          seg_start, seg_end;
    pps_pkg::pps_item_t        item;

    // Effective sizes: zero acts as one, oversize acts as the maximum.
    always_comb
    begin
        priority if (width_cfg == '0)
        begin
            w_eff = CMP_W'(1);
        end
        else if (CMP_W'(width_cfg) > CMP_W'(MAX_WIDTH))
        begin
            w_eff = CMP_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = CMP_W'(width_cfg);
        end
        priority if (height_cfg == '0)
        begin
            h_eff = CMP_W'(1);
        end
        else if (CMP_W'(height_cfg) > CMP_W'(MAX_HEIGHT))
        begin
            h_eff = CMP_W'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = CMP_W'(height_cfg);
        end
    end

    // Row end and frame end detection.
    always_comb
    begin
        nz       = (pixel_value != '0);
        acc_sum  = pps_pkg::sat_inc(acc_reg, nz);
        col_inc  = CMP_W'(col_reg) + CMP_W'(1);
        row_inc  = CMP_W'(row_reg) + CMP_W'(1);
        last_col = (col_inc >= w_eff);
        last_row = (row_inc >= h_eff);
        rcol_ext = CMP_W'(read_column);
    end

    // Run detection at the end of a row.
    always_comb
    begin
        seg_valid      = 1'b0;
        seg_start      = '0;
        seg_end        = '0;
        run_open_next  = run_open_reg;
        run_start_next = run_start_reg;
        if (acc_sum != '0)
        begin
            run_start_next = run_open_reg ? run_start_reg : row_reg;
            if (last_row)
            begin
                seg_valid     = 1'b1;
                seg_start     = run_start_next;
                seg_end       = row_reg;
                run_open_next = 1'b0;
            end
            else
            begin
                run_open_next = 1'b1;
            end
        end
        else if (run_open_reg)
        begin
            seg_valid     = 1'b1;
            seg_start     = run_start_reg;
            seg_end       = row_reg - ROW_W'(1);
            run_open_next = 1'b0;
        end
        if (last_row)
        begin
            run_open_next = 1'b0;
        end
    end

    // Position state and the word for the next stage.
    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        acc_next  = acc_reg;
        row_ext   = CMP_W'(row_reg);
        start_ext = CMP_W'(seg_start);
        end_ext   = CMP_W'(seg_end);
        item      = '0;
        item.nz   = nz;
        item.first_row = (row_reg == '0);
        if (func == pps_pkg::FUNC_READ)
        begin
            rd_addr        = rcol_ext[COL_W-1:0];
            item.is_read   = 1'b1;
            item.in_range  = (rcol_ext < CMP_W'(MAX_WIDTH));
            item.has_res   = 1'b1;
            item.position  = read_column;
        end
        else
        begin
            rd_addr = col_reg;
            if (!last_col)
            begin
                col_next = col_inc[COL_W-1:0];
                acc_next = acc_sum;
            end
            else
            begin
                col_next       = '0;
                acc_next       = '0;
                row_next       = last_row ? '0 : row_inc[ROW_W-1:0];
                item.has_res   = 1'b1;
                item.position  = row_ext[pps_pkg::POS_W-1:0];
                item.row_count = acc_sum;
                item.seg_valid = seg_valid;
                item.seg_start = start_ext[pps_pkg::POS_W-1:0];
                item.seg_end   = end_ext[pps_pkg::POS_W-1:0];
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            acc_reg       <= '0;
            run_open_reg  <= 1'b0;
            run_start_reg <= '0;
            s1_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept && (func == pps_pkg::FUNC_PIXEL))
            begin
                col_reg <= col_next;
                row_reg <= row_next;
                acc_reg <= acc_next;
                if (last_col)
                begin
                    run_open_reg  <= run_open_next;
                    run_start_reg <= run_start_next;
                end
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    // Stage payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= item;
            s1_addr_reg <= rd_addr;
        end
    end

endmodule

`default_nettype wire

@@ hdl/pps_colupd.sv @@
// ----------------------------------------------------------------------------
// pps_colupd
// Column count read-modify-write with write forwarding, and the output
// word register.
// ----------------------------------------------------------------------------
`default_nettype none

module pps_colupd #(
    parameter int MAX_WIDTH = pps_pkg::MAX_WIDTH_DEF
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 s1_valid,
    input  pps_pkg::pps_item_t                  s1_item,
    input  wire  [$clog2(MAX_WIDTH)-1:0]        s1_addr,
    input  wire  [pps_pkg::CNT_W-1:0]           rd_data,
    output logic                                s1_adv,
    output logic                                wr_en,
    output logic [$clog2(MAX_WIDTH)-1:0]        wr_addr,
    output logic [pps_pkg::CNT_W-1:0]           wr_data,
    output logic                                out_valid_reg,
    input  wire                                 out_ready,
    output logic                                out_kind_reg,
    output logic [pps_pkg::OUT_DATA_W-1:0]      out_data_reg
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int PAD_W = pps_pkg::OUT_DATA_W - pps_pkg::CNT_W
                           - 3 * pps_pkg::POS_W - 1;

    logic                      fwd_valid_reg;
    logic [COL_W-1:0]          fwd_addr_reg;
    logic [pps_pkg::CNT_W-1:0] fwd_data_reg;
    logic [pps_pkg::CNT_W-1:0] old_cnt, new_cnt, res_cnt;
    logic                      out_free, load;

    // Latest value of the column: the last write wins over the memory.
    always_comb
    begin
        old_cnt = (fwd_valid_reg && (fwd_addr_reg == s1_addr)) ? fwd_data_reg : rd_data;
        new_cnt = s1_item.first_row ? pps_pkg::CNT_W'(s1_item.nz)
                                    : pps_pkg::sat_inc(old_cnt, s1_item.nz);
        res_cnt = s1_item.is_read ? (s1_item.in_range ? old_cnt : '0)
                                  : s1_item.row_count;
    end

    // Stage advance and write back.
    always_comb
    begin
        out_free = !out_valid_reg || out_ready;
        s1_adv   = !s1_valid || !s1_item.has_res || out_free;
        load     = s1_valid && s1_item.has_res && out_free;
        wr_en    = s1_valid && !s1_item.is_read && s1_adv;
        wr_addr  = s1_addr;
        wr_data  = new_cnt;
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                fwd_valid_reg <= 1'b1;
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Forwarding copy and output word.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            fwd_addr_reg <= wr_addr;
            fwd_data_reg <= wr_data;
        end
        if (load)
        begin
            out_kind_reg <= s1_item.is_read ? pps_pkg::KIND_COL : pps_pkg::KIND_ROW;
            out_data_reg <= {{PAD_W{1'b0}}, s1_item.seg_end, s1_item.seg_start,
                             s1_item.seg_valid, res_cnt, s1_item.position};
        end
    end

endmodule

`default_nettype wire

@@ hdl/projection_profile_segmenter_top.sv @@
// ----------------------------------------------------------------------------
// projection_profile_segmenter_top
// Row and column projection profiles of a raster pixel stream with detection
// of runs of nonzero rows.
// ----------------------------------------------------------------------------
// Usage: pixels enter on the s_ channel in raster order with s_tuser low; a
// word with s_tuser high asks for the count of one column instead. At the
// last pixel of each row a row summary word leaves on the m_ channel with the
// row index, its nonzero count and, when a run of nonzero rows closed there,
// the run's first and last row. A column read gives one word with the count.
// The cfg_ channel writes image width (index 0) and height (index 1); it is
// always ready; the user must write it only while the block is idle, which
// the block does not enforce. Throughput is one word per clock while s_tready
// is high. Column counts sit in one RAM; each pixel reads its column on
// acceptance and writes the new count when the s1 stage advances, with a
// forwarding register covering back-to-back hits on one column.
// Reset clears positions, the row count and the open run; the column RAM is
// not cleared, the first row of each frame overwrites it.
// When m_tready is low, words without a result keep flowing; s_tready drops
// only when a result word cannot move into the held output register.
// ----------------------------------------------------------------------------
`default_nettype none

module projection_profile_segmenter_top #(
    parameter int MAX_WIDTH  = pps_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = pps_pkg::MAX_HEIGHT_DEF
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    // Input stream.
    input  wire                                 s_tvalid,
    output logic                                s_tready,
    input  wire  [pps_pkg::IN_DATA_W-1:0]       s_tdata,  // pixel_value, read_column
    input  wire                                 s_tuser,  // func
    // Output stream.
    output logic                                m_tvalid,
    input  wire                                 m_tready,
    output logic [pps_pkg::OUT_DATA_W-1:0]      m_tdata,  // position, pixel_count,
                                                          // segment_valid,
                                                          // segment_start, segment_end
    output logic                                m_tuser,  // kind
    // Configuration writes.
    input  wire                                 cfg_valid,
    output logic                                cfg_ready,
    input  wire  [pps_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire  [pps_pkg::CFG_W-1:0]           cfg_data
);

    localparam int COL_W = $clog2(MAX_WIDTH);

    logic [pps_pkg::CFG_W-1:0] width_reg, height_reg;
    logic                      accept, s1_valid, s1_adv, wr_en;
    pps_pkg::pps_item_t        s1_item;
    logic [COL_W-1:0]          rd_addr, s1_addr, wr_addr;
    logic [pps_pkg::CNT_W-1:0] rd_data, wr_data;

    assign cfg_ready = 1'b1;
    assign s_tready  = s1_adv;
    assign accept    = s_tvalid && s1_adv;

    // Size registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= pps_pkg::WIDTH_RST;
            height_reg <= pps_pkg::HEIGHT_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                pps_pkg::REG_WIDTH:  width_reg  <= cfg_data;
                pps_pkg::REG_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Position tracking and run detection.
    pps_frame #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_frame (
        .clk          (clk),
        .rst_n        (rst_n),
        .width_cfg    (width_reg),
        .height_cfg   (height_reg),
        .accept       (accept),
        .func         (s_tuser),
        .pixel_value  (s_tdata[pps_pkg::PIX_W-1:0]),
        .read_column  (s_tdata[pps_pkg::PIX_W +: pps_pkg::POS_W]),
        .rd_addr      (rd_addr),
        .s1_valid_reg (s1_valid),
        .s1_item_reg  (s1_item),
        .s1_addr_reg  (s1_addr),
        .s1_adv       (s1_adv)
    );

    // Column count memory.
    pps_ram #(
        .WIDTH (pps_pkg::CNT_W),
        .DEPTH (MAX_WIDTH)
    ) u_col_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Column update and output register.
    pps_colupd #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_colupd (
        .clk           (clk),
        .rst_n         (rst_n),
        .s1_valid      (s1_valid),
        .s1_item       (s1_item),
        .s1_addr       (s1_addr),
        .rd_data       (rd_data),
        .s1_adv        (s1_adv),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data),
        .out_valid_reg (m_tvalid),
        .out_ready     (m_tready),
        .out_kind_reg  (m_tuser),
        .out_data_reg  (m_tdata)
    );

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// Projection profile segmenter testbench
// Sends pixel and column-read words, predicts every row summary and column
// count in a behavioral profile tracker, and checks each output word against
// the oldest prediction. Directed tests cover the size extremes, run closing
// and mid-row resizes. Random traffic with random gaps and stalls follows.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pps_pkg::*;

    localparam int MAX_W = MAX_WIDTH_DEF;
    localparam int MAX_H = MAX_HEIGHT_DEF;
    localparam int RANDOM_WORDS = 130;
    localparam int TALL_ROWS = 48;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS = 10;

    // Bit offsets of the output word fields in m_tdata.
    localparam int OFS_COUNT = POS_W;
    localparam int OFS_SEGV  = OFS_COUNT + CNT_W;
    localparam int OFS_SEGS  = OFS_SEGV + 1;
    localparam int OFS_SEGE  = OFS_SEGS + POS_W;

    typedef struct packed {
        logic             kind;
        logic [POS_W-1:0] position;
        logic [CNT_W-1:0] count;
        logic             seg_valid;
        logic [POS_W-1:0] seg_start;
        logic [POS_W-1:0] seg_end;
    } profile_word_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]      cfg_data = '0;

    // Predicted profile tracker state.
    logic [CNT_W-1:0] col_count [0:MAX_W-1];
    bit               col_seen [0:MAX_W-1];
    int               col_pos = 0;
    int               row_pos = 0;
    logic [CNT_W-1:0] row_sum = '0;
    bit               run_open = 1'b0;
    int               run_first = 0;
    logic [CFG_W-1:0] width_reg = WIDTH_RST;
    logic [CFG_W-1:0] height_reg = HEIGHT_RST;

    profile_word_t profile_q[$];
    int            mismatch_count = 0;
    int            idle_cycles = 0;
    int            stall_left = 0;
    bit            no_gap = 1'b0;
    bit            no_stall = 1'b0;

    projection_profile_segmenter_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Size register as the block uses it: zero acts as one, oversize clamps.
    function automatic int eff_size(input logic [CFG_W-1:0] v, input int maxv);
        if (v == '0)
        begin
            return 1;
        end
        if (int'(v) > maxv)
        begin
            return maxv;
        end
        return int'(v);
    endfunction

    function automatic logic [CNT_W-1:0] count_up(input logic [CNT_W-1:0] c,
                                                  input logic nz);
        int s;
        s = int'(c) + int'(nz);
        return (s > 2047) ? CNT_W'(2047) : CNT_W'(s);
    endfunction

    // Append one predicted word behind the ones still waiting.
    function automatic void queue_word(input profile_word_t w);
        profile_q.insert(profile_q.size(), w);
    endfunction

    // Advance the profile tracker by one accepted word and queue any result.
    function automatic void project_item(input logic func, input logic [PIX_W-1:0] pix,
                                         input logic [POS_W-1:0] rcol);
        profile_word_t w;
        int            wd;
        int            ht;
        int            col;
        int            row;
        logic          nz;
        bit            last_row;
        w = '0;
        wd = eff_size(width_reg, MAX_W);
        ht = eff_size(height_reg, MAX_H);
        if (func == FUNC_READ)
        begin
            w.kind = KIND_COL;
            w.position = rcol;
            w.count = col_count[rcol];
            queue_word(w);
            return;
        end
        nz = (pix != '0);
        col = col_pos;
        row = row_pos;
        // The first row of a frame overwrites the column count.
        if (col < MAX_W)
        begin
            col_count[col] = (row == 0) ? CNT_W'(nz) : count_up(col_count[col], nz);
            col_seen[col] = 1'b1;
        end
        row_sum = count_up(row_sum, nz);
        if (col + 1 < wd)
        begin
            col_pos = col + 1;
            return;
        end
        // Row end: summary plus run detection.
        last_row = (row + 1 >= ht);
        w.kind = KIND_ROW;
        w.position = POS_W'(row);
        w.count = row_sum;
        if (row_sum != '0)
        begin
            if (!run_open)
            begin
                run_open = 1'b1;
                run_first = row;
            end
            if (last_row)
            begin
                w.seg_valid = 1'b1;
                w.seg_start = POS_W'(run_first);
                w.seg_end = POS_W'(row);
                run_open = 1'b0;
            end
        end
        else if (run_open)
        begin
            w.seg_valid = 1'b1;
            w.seg_start = POS_W'(run_first);
            w.seg_end = POS_W'(row - 1);
            run_open = 1'b0;
        end
        queue_word(w);
        row_sum = '0;
        col_pos = 0;
        if (last_row)
        begin
            row_pos = 0;
            run_open = 1'b0;
        end
        else
        begin
            row_pos = row + 1;
        end
    endfunction

    // Send one word after a random gap and predict it on acceptance.
    task automatic send_word(input logic func, input logic [PIX_W-1:0] pix,
                             input logic [POS_W-1:0] rcol);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= func;
        s_tdata <= {{(IN_DATA_W-PIX_W-POS_W){1'b0}}, rcol, pix};
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        project_item(func, pix, rcol);
    endtask

    // Stop sending and wait until every predicted word has come out.
    task automatic settle_block();
        s_tvalid <= 1'b0;
        while (profile_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        if (idx == REG_WIDTH)
        begin
            width_reg = v;
        end
        else
        begin
            height_reg = v;
        end
    endtask

    task automatic set_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        settle_block();
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        cfg_valid <= 1'b0;
    endtask

    task automatic note_mismatch(input string field, input int want, input int got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
        begin
            $display("mismatch in %s: expected %0d, got %0d", field, want, got);
        end
    endtask

    // Compare one output word with the oldest prediction.
    task automatic check_word(input logic [OUT_DATA_W-1:0] data, input logic user);
        profile_word_t got;
        profile_word_t want;
        got.kind = user;
        got.position = data[POS_W-1:0];
        got.count = data[OFS_COUNT +: CNT_W];
        got.seg_valid = data[OFS_SEGV];
        got.seg_start = data[OFS_SEGS +: POS_W];
        got.seg_end = data[OFS_SEGE +: POS_W];
        if (profile_q.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
            begin
                $display("output word with nothing predicted: tuser %0b tdata %h",
                         user, data);
            end
            return;
        end
        want = profile_q.pop_front();
        if (got.kind !== want.kind)
            note_mismatch("kind", want.kind, got.kind);
        if (got.position !== want.position)
            note_mismatch("position", want.position, got.position);
        if (got.count !== want.count)
            note_mismatch("pixel_count", want.count, got.count);
        if (got.seg_valid !== want.seg_valid)
            note_mismatch("segment_valid", want.seg_valid, got.seg_valid);
        if (got.seg_start !== want.seg_start)
            note_mismatch("segment_start", want.seg_start, got.seg_start);
        if (got.seg_end !== want.seg_end)
            note_mismatch("segment_end", want.seg_end, got.seg_end);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            check_word(m_tdata, m_tuser);
        end
    end

    // Output side: after each word, hold ready low for a random stall.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stall_left = 0;
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                stall_left = no_stall ? 0 : $urandom_range(0, 19);
            end
            else if (stall_left > 0)
            begin
                stall_left = stall_left - 1;
            end
            m_tready <= (stall_left == 0);
        end
    end

    // Watchdog on cycles where no channel moves a word.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles = idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // One-pixel frames from zero size registers; a run at row 0 closes at once.
    task automatic test_single_pixel_frames();
        set_size('0, '0);
        send_word(FUNC_PIXEL, 8'd0, '0);
        send_word(FUNC_PIXEL, 8'd255, '0);
        send_word(FUNC_PIXEL, 8'd1, '0);
        send_word(FUNC_READ, '0, '0);
    endtask

    // Runs closed by a zero row and by the last row, plus column accumulation.
    task automatic test_row_runs();
        set_size(11'd2, 11'd5);
        send_word(FUNC_PIXEL, 8'd255, '0);
        send_word(FUNC_PIXEL, 8'd0, '0);
        send_word(FUNC_PIXEL, 8'd0, '0);
        send_word(FUNC_PIXEL, 8'd128, '0);
        send_word(FUNC_PIXEL, 8'd0, '0);
        send_word(FUNC_PIXEL, 8'd0, '0);
        send_word(FUNC_PIXEL, 8'd1, '0);
        send_word(FUNC_PIXEL, 8'd0, '0);
        send_word(FUNC_PIXEL, 8'd7, '0);
        send_word(FUNC_PIXEL, 8'd7, '0);
        send_word(FUNC_READ, '0, 10'd0);
        send_word(FUNC_READ, '0, 10'd1);
        // Row 0 of the next frame overwrites column 0.
        send_word(FUNC_PIXEL, 8'd0, '0);
        send_word(FUNC_READ, '0, 10'd0);
    endtask

    // Width and height shrink while a row and a frame are in progress.
    task automatic test_resize_mid_row();
        set_size(11'd8, 11'd4);
        send_word(FUNC_PIXEL, 8'd9, '0);
        send_word(FUNC_PIXEL, 8'd0, '0);
        send_word(FUNC_PIXEL, 8'd200, '0);
        send_word(FUNC_PIXEL, 8'd0, '0);
        set_size(11'd3, 11'd4);
        send_word(FUNC_PIXEL, 8'd0, '0);
        set_size(11'd3, 11'd1);
        send_word(FUNC_PIXEL, 8'd4, '0);
        send_word(FUNC_PIXEL, 8'd0, '0);
        send_word(FUNC_PIXEL, 8'd0, '0);
    endtask

    // Oversized width acting as the widest row; reads reach every column bit.
    task automatic test_wide_row();
        set_size(11'd2047, 11'd1);
        for (int i = 0; i < MAX_W; i++)
        begin
            send_word(FUNC_PIXEL, $urandom_range(0, 1) ? PIX_W'($urandom_range(1, 255)) : '0,
                      POS_W'($urandom));
        end
        send_word(FUNC_READ, '0, 10'h3FF);
        send_word(FUNC_READ, '0, 10'h200);
        send_word(FUNC_READ, 8'hFF, 10'h000);
        send_word(FUNC_READ, '0, 10'h2AA);
        send_word(FUNC_READ, '0, 10'h155);
    endtask

    // A one-column frame, one pixel per row, with a run open at the last row.
    task automatic test_tall_frame();
        set_size(11'd1, CFG_W'(TALL_ROWS));
        for (int i = 0; i < TALL_ROWS; i++)
        begin
            send_word(FUNC_PIXEL, ((i % 11) < 6) ? PIX_W'($urandom_range(1, 255)) : '0,
                      POS_W'($urandom));
        end
        send_word(FUNC_READ, '0, 10'd0);
    endtask

    // Random phases of narrow frames with mixed row content and column reads.
    task automatic test_random_traffic();
        int            sent;
        int            n;
        int            r;
        int            row_mode;
        logic [CFG_W-1:0] w;
        logic [CFG_W-1:0] h;
        logic [POS_W-1:0] rcol;
        logic [PIX_W-1:0] pix;
        sent = 0;
        row_mode = 0;
        while (sent < RANDOM_WORDS)
        begin
            r = $urandom_range(0, 9);
            w = (r == 0) ? '0 : (r == 1) ? CFG_W'($urandom_range(9, 24))
                                        : CFG_W'($urandom_range(1, 8));
            r = $urandom_range(0, 9);
            h = (r == 0) ? '0 : (r == 1) ? CFG_W'(2047) : (r == 2) ?
                CFG_W'($urandom_range(9, 16)) : CFG_W'($urandom_range(1, 8));
            set_size(w, h);
            no_gap = ($urandom_range(0, 3) == 0);
            no_stall = ($urandom_range(0, 3) == 0);
            n = $urandom_range(30, 120);
            for (int i = 0; i < n; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    rcol = ($urandom_range(0, 3) == 0) ? POS_W'($urandom)
                                                       : POS_W'($urandom_range(0, 15));
                    if (!col_seen[rcol])
                    begin
                        rcol = '0;
                    end
                    send_word(FUNC_READ, PIX_W'($urandom), rcol);
                end
                else
                begin
                    // Pick zero, sparse or dense content at each row start.
                    if (col_pos == 0)
                    begin
                        row_mode = $urandom_range(0, 2);
                    end
                    r = $urandom_range(0, 9);
                    if ((row_mode == 1 && r < 2) || (row_mode == 2 && r < 8))
                    begin
                        pix = PIX_W'($urandom_range(1, 255));
                    end
                    else
                    begin
                        pix = '0;
                    end
                    send_word(FUNC_PIXEL, pix, POS_W'($urandom));
                end
            end
            sent = sent + n;
        end
        no_gap = 1'b0;
        no_stall = 1'b0;
    endtask

    initial
    begin
        for (int i = 0; i < MAX_W; i++)
        begin
            col_count[i] = '0;
            col_seen[i] = 1'b0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_single_pixel_frames();
        test_row_runs();
        test_resize_mid_row();
        test_wide_row();
        test_tall_frame();
        test_random_traffic();
        settle_block();
        repeat (4) @(posedge clk);
        if (mismatch_count == 0 && profile_q.size() == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
